/* design/jcmp_pkg.sv */
package jcmp_pkg;

    localparam int NAME_BYTES = 50;

    localparam logic [7:0] CHAR_I = 8'h49;
    localparam logic [7:0] CHAR_F = 8'h46;
    localparam logic [7:0] CHAR_B = 8'h42;

    localparam logic [31:0] ERR_BAD_TAG   = 32'd0;
    localparam logic [31:0] ERR_TRUNCATED = 32'd1;

    typedef enum logic [2:0] {
        KIND_JOINT_CHAR = 3'd0,
        KIND_CMD_LEN    = 3'd1,
        KIND_VAL_COUNT  = 3'd2,
        KIND_CMD_CHAR   = 3'd3,
        KIND_INT        = 3'd4,
        KIND_FLOAT      = 3'd5,
        KIND_BOOL       = 3'd6,
        KIND_ERROR      = 3'd7
    } kind_t;

    // one buffered input request
    typedef struct packed {
        logic [7:0] byte_in;
        logic       end_of_buffer;
    } req_t;

endpackage

/* design/jcmp_if.sv */
interface jcmp_msg_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_in;
    logic       end_of_buffer;

    modport source (output valid, output byte_in, output end_of_buffer, input ready);
    modport sink   (input valid, input byte_in, input end_of_buffer, output ready);
endinterface

interface jcmp_field_if;
    logic              valid;
    logic              ready;
    jcmp_pkg::kind_t   kind;
    logic [31:0]       payload;
    logic              message_done;

    modport source (output valid, output kind, output payload, output message_done,
                    input ready);
    modport sink   (input valid, input kind, input payload, input message_done,
                    output ready);
endinterface

/* design/joint_command_message_parser.sv */
// Joint command message parser.
// msg: one serialized byte per request, with end_of_buffer set on the last
//   byte of a buffer. The message is a 50-byte joint name, a command length,
//   a value count, the command bytes, then tagged values (I int, F float
//   bits, B bool), multi-byte values little-endian.
// field: zero or one request per input byte, carrying kind, payload and
//   message_done. Errors (kind 7) report a bad tag (payload 0) or a buffer
//   that ends before the message is complete (payload 1).
// Path: a byte accepted into the input register is parsed from there into the
//   output register, which drives its field request.
// Throughput: one byte per cycle while the output is not stalled, set by the
//   single parse step between the input register and the output register.
// Stall: while field.ready is low and a field request is held, the parser
//   holds its state; an empty input register still takes one more byte, then
//   msg.ready stays low until the output drains.
// Reset: both registers empty, parser waiting for the first joint name byte.
// The end_of_buffer byte also returns the parser to that state.
module joint_command_message_parser (
    input  logic          clk,
    input  logic          rst_n,
    jcmp_msg_if.sink      msg,
    jcmp_field_if.source  field
);
    import jcmp_pkg::*;

    logic req_valid;
    req_t req;
    logic consume;

    jcmp_in_stage u_in_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .msg       (msg),
        .req_valid (req_valid),
        .req       (req),
        .consume   (consume)
    );

    jcmp_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req       (req),
        .consume   (consume),
        .field     (field)
    );

    // a completed message is never an error
    assert property (@(posedge clk) disable iff (!rst_n)
        field.valid && field.message_done |-> field.kind != KIND_ERROR)
        else $error("message_done set on an error");

    assert property (@(posedge clk) disable iff (!rst_n)
        field.valid && field.kind == KIND_ERROR |->
            field.payload == ERR_BAD_TAG || field.payload == ERR_TRUNCATED)
        else $error("unexpected error code");

    // a buffered byte not parsed this cycle stays buffered unchanged
    assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !consume |=> req_valid && $stable(req))
        else $error("buffered byte lost while stalled");

    // parse only happens when the output register can take the result
    assert property (@(posedge clk) disable iff (!rst_n)
        consume |-> !field.valid || field.ready)
        else $error("parse step while output stalled");

endmodule

/* design/jcmp_in_stage.sv */
module jcmp_in_stage (
    input  logic             clk,
    input  logic             rst_n,
    jcmp_msg_if.sink         msg,
    output logic             req_valid,
    output jcmp_pkg::req_t   req,
    input  logic             consume
);
    import jcmp_pkg::*;

    logic valid_reg;
    req_t req_reg;

    // take a new byte when empty or when the held one leaves this cycle
    assign msg.ready = !valid_reg || consume;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (msg.ready)
        begin
            valid_reg <= msg.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (msg.ready && msg.valid)
        begin
            req_reg.byte_in       <= msg.byte_in;
            req_reg.end_of_buffer <= msg.end_of_buffer;
        end
    end

    assign req_valid = valid_reg;
    assign req       = req_reg;

endmodule

/* design/jcmp_core.sv */
module jcmp_core (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             req_valid,
    input  jcmp_pkg::req_t   req,
    output logic             consume,
    jcmp_field_if.source     field
);
    import jcmp_pkg::*;

    typedef enum logic [2:0] {
        PH_NAME,
        PH_CMDLEN,
        PH_VALCNT,
        PH_CMD,
        PH_TAG,
        PH_VALUE,
        PH_IDLE
    } phase_t;

    typedef enum logic [1:0] {
        TAG_INT,
        TAG_FLOAT,
        TAG_BOOL
    } tag_t;

    phase_t      phase_reg, phase_next;
    logic [7:0]  field_counter_reg, field_counter_next;
    logic [7:0]  command_remaining_reg, command_remaining_next;
    logic [7:0]  values_remaining_reg, values_remaining_next;
    logic        name_terminated_reg, name_terminated_next;
    tag_t        current_tag_reg, current_tag_next;
    logic [31:0] value_shift_reg, value_shift_next;
    logic [1:0]  value_byte_index_reg, value_byte_index_next;

    logic        out_valid_reg, out_valid_next;
    kind_t       out_kind_reg, out_kind_next;
    logic [31:0] out_payload_reg, out_payload_next;
    logic        out_done_reg, out_done_next;

    logic        have;
    kind_t       kind;
    logic [31:0] payload;
    logic        done;
    logic        bad_tag;
    logic [7:0]  cnt_inc;
    logic [7:0]  cmd_dec;
    logic [7:0]  val_dec;
    logic [31:0] lane_word;
    logic [7:0]  b;

    assign b       = req.byte_in;
    assign consume = req_valid && (!out_valid_reg || field.ready);

    assign cnt_inc   = field_counter_reg + 8'd1;
    assign cmd_dec   = command_remaining_reg - 8'd1;
    assign val_dec   = values_remaining_reg - 8'd1;
    assign lane_word = {24'd0, b} << {value_byte_index_reg, 3'b000};

    always_comb
    begin
        phase_next             = phase_reg;
        field_counter_next     = field_counter_reg;
        command_remaining_next = command_remaining_reg;
        values_remaining_next  = values_remaining_reg;
        name_terminated_next   = name_terminated_reg;
        current_tag_next       = current_tag_reg;
        value_shift_next       = value_shift_reg;
        value_byte_index_next  = value_byte_index_reg;
        have    = 1'b0;
        kind    = KIND_JOINT_CHAR;
        payload = 32'd0;
        done    = 1'b0;
        bad_tag = 1'b0;

        unique case (phase_reg)
            PH_NAME:
            begin
                if (!name_terminated_reg)
                begin
                    if (b == 8'd0)
                    begin
                        name_terminated_next = 1'b1;
                    end
                    else
                    begin
                        have    = 1'b1;
                        kind    = KIND_JOINT_CHAR;
                        payload = {24'd0, b};
                    end
                end
                field_counter_next = cnt_inc;
                if (cnt_inc >= 8'(NAME_BYTES))
                begin
                    phase_next = PH_CMDLEN;
                end
            end
            PH_CMDLEN:
            begin
                command_remaining_next = b;
                have       = 1'b1;
                kind       = KIND_CMD_LEN;
                payload    = {24'd0, b};
                phase_next = PH_VALCNT;
            end
            PH_VALCNT:
            begin
                values_remaining_next = b;
                have    = 1'b1;
                kind    = KIND_VAL_COUNT;
                payload = {24'd0, b};
                if (command_remaining_reg != 8'd0)
                begin
                    phase_next = PH_CMD;
                end
                else if (b != 8'd0)
                begin
                    phase_next = PH_TAG;
                end
                else
                begin
                    phase_next = PH_IDLE;
                    done       = 1'b1;
                end
            end
            PH_CMD:
            begin
                have    = 1'b1;
                kind    = KIND_CMD_CHAR;
                payload = {24'd0, b};
                command_remaining_next = cmd_dec;
                if (cmd_dec == 8'd0)
                begin
                    if (values_remaining_reg != 8'd0)
                    begin
                        phase_next = PH_TAG;
                    end
                    else
                    begin
                        phase_next = PH_IDLE;
                        done       = 1'b1;
                    end
                end
            end
            PH_TAG:
            begin
                if (b == CHAR_I || b == CHAR_F || b == CHAR_B)
                begin
                    current_tag_next      = (b == CHAR_I) ? TAG_INT :
                                            (b == CHAR_F) ? TAG_FLOAT : TAG_BOOL;
                    value_shift_next      = 32'd0;
                    value_byte_index_next = 2'd0;
                    phase_next            = PH_VALUE;
                end
                else
                begin
                    have       = 1'b1;
                    kind       = KIND_ERROR;
                    payload    = ERR_BAD_TAG;
                    bad_tag    = 1'b1;
                    phase_next = PH_IDLE;
                end
            end
            PH_VALUE:
            begin
                if (current_tag_reg == TAG_BOOL)
                begin
                    have    = 1'b1;
                    kind    = KIND_BOOL;
                    payload = {31'd0, (b != 8'd0)};
                    values_remaining_next = val_dec;
                    done       = (val_dec == 8'd0);
                    phase_next = (val_dec == 8'd0) ? PH_IDLE : PH_TAG;
                end
                else
                begin
                    value_shift_next = value_shift_reg | lane_word;
                    if (value_byte_index_reg == 2'd3)
                    begin
                        have    = 1'b1;
                        kind    = (current_tag_reg == TAG_FLOAT) ? KIND_FLOAT : KIND_INT;
                        payload = value_shift_reg | lane_word;
                        value_byte_index_next = 2'd0;
                        values_remaining_next = val_dec;
                        done       = (val_dec == 8'd0);
                        phase_next = (val_dec == 8'd0) ? PH_IDLE : PH_TAG;
                    end
                    else
                    begin
                        value_byte_index_next = value_byte_index_reg + 2'd1;
                    end
                end
            end
            PH_IDLE:
            begin
            end
            default:
            begin
            end
        endcase

        // end of buffer: flag a short message, then start over
        if (req.end_of_buffer)
        begin
            if (phase_next != PH_IDLE && !bad_tag)
            begin
                have    = 1'b1;
                kind    = KIND_ERROR;
                payload = ERR_TRUNCATED;
                done    = 1'b0;
            end
            phase_next             = PH_NAME;
            field_counter_next     = 8'd0;
            command_remaining_next = 8'd0;
            values_remaining_next  = 8'd0;
            name_terminated_next   = 1'b0;
            current_tag_next       = TAG_INT;
            value_shift_next       = 32'd0;
            value_byte_index_next  = 2'd0;
        end
    end

    always_comb
    begin
        out_kind_next    = out_kind_reg;
        out_payload_next = out_payload_reg;
        out_done_next    = out_done_reg;
        if (consume)
        begin
            out_valid_next = have;
            if (have)
            begin
                out_kind_next    = kind;
                out_payload_next = payload;
                out_done_next    = done;
            end
        end
        else if (field.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg             <= PH_NAME;
            field_counter_reg     <= 8'd0;
            command_remaining_reg <= 8'd0;
            values_remaining_reg  <= 8'd0;
            name_terminated_reg   <= 1'b0;
            current_tag_reg       <= TAG_INT;
            value_shift_reg       <= 32'd0;
            value_byte_index_reg  <= 2'd0;
            out_valid_reg         <= 1'b0;
            out_kind_reg          <= KIND_JOINT_CHAR;
            out_payload_reg       <= 32'd0;
            out_done_reg          <= 1'b0;
        end
        else
        begin
            if (consume)
            begin
                phase_reg             <= phase_next;
                field_counter_reg     <= field_counter_next;
                command_remaining_reg <= command_remaining_next;
                values_remaining_reg  <= values_remaining_next;
                name_terminated_reg   <= name_terminated_next;
                current_tag_reg       <= current_tag_next;
                value_shift_reg       <= value_shift_next;
                value_byte_index_reg  <= value_byte_index_next;
            end
            out_valid_reg   <= out_valid_next;
            out_kind_reg    <= out_kind_next;
            out_payload_reg <= out_payload_next;
            out_done_reg    <= out_done_next;
        end
    end

    assign field.valid        = out_valid_reg;
    assign field.kind         = out_kind_reg;
    assign field.payload      = out_payload_reg;
    assign field.message_done = out_done_reg;

endmodule
